### design/bfr_pkg.sv
package bfr_pkg;

  localparam int DATA_W          = 8;
  localparam int LEN_W           = 7;
  localparam int CFG_IDX_W       = 2;
  localparam int FRAME_DEPTH_DEF = 64;

  localparam logic [DATA_W-1:0] ESC_FLIP       = 8'h20;
  localparam logic [DATA_W-1:0] START_BYTE_RST = 8'h7E;
  localparam logic [DATA_W-1:0] STOP_BYTE_RST  = 8'h7E;
  localparam logic [DATA_W-1:0] ESC_BYTE_RST   = 8'h7D;

  typedef enum logic [2:0] {
    ST_DATA      = 3'd0,
    ST_ESC_ERR   = 3'd1,
    ST_STOP_IDLE = 3'd2,
    ST_START_IN  = 3'd3,
    ST_OVERSIZE  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START  = 2'd0,
    CFG_STOP   = 2'd1,
    CFG_ESCAPE = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    EM_IDLE = 1'b0,
    EM_RUN  = 1'b1
  } em_state_t;

  // parser -> emitter
  typedef struct packed {
    logic             rpt_valid;
    status_t          rpt_code;
    logic             emit_start;
    logic [LEN_W-1:0] emit_len;
  } bfr_ctl_t;

  // emitter -> parser
  typedef struct packed {
    logic busy;
    logic rpt_take;
  } bfr_em_stat_t;

endpackage

### design/bfr_in_if.sv
interface bfr_in_if import bfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### design/bfr_out_if.sv
interface bfr_out_if import bfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] frame_byte;
  logic [2:0]        status;
  logic              last;

  modport source (output valid, output frame_byte, output status, output last, input ready);
  modport sink   (input valid, input frame_byte, input status, input last, output ready);
endinterface

### design/bfr_cfg_if.sv
interface bfr_cfg_if import bfr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/byte_stuffed_frame_receiver_top.sv
// Byte-stuffed frame receiver. Raw line bytes go in on in_bus; escapes are
// removed (the byte after the escape byte is XORed with 0x20) and a frame,
// start byte through stop byte, is held in an on-chip RAM of FRAME_DEPTH
// bytes. When the stop byte arrives the frame is read back out on out_bus,
// one beat per byte, with last set on the closing byte. Framing faults
// (escape error, stop while idle, start during frame, oversize) each give a
// single beat with frame_byte zero, the fault code in status and last set.
// Flow: a byte that neither ends a frame nor raises a fault leaves in_bus
// ready. A closing stop byte starts a read-out of n bytes through the RAM's
// single read port: a RAM read, then one beat per cycle while out_bus is
// ready; in_bus is held off until read-out ends. A fault report sits in a
// one-deep holding register and in_bus waits until it moves into the output
// register. No RAM clearing pass after reset; the block is ready at once.
// Configuration writes (index 0 start, 1 stop, 2 escape) are always ready
// and must be made while the block is idle.
module byte_stuffed_frame_receiver_top import bfr_pkg::*; #(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bfr_in_if.sink     in_bus,
  bfr_out_if.source  out_bus,
  bfr_cfg_if.sink    cfg_bus
);

  localparam int AW = $clog2(FRAME_DEPTH);

  bfr_ctl_t          ctl;
  bfr_em_stat_t      em_stat;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, rd_data;

  bfr_parser #(.FRAME_DEPTH(FRAME_DEPTH)) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .cfg_bus (cfg_bus),
    .em_stat (em_stat),
    .ctl     (ctl),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bfr_ram #(.WIDTH(DATA_W), .DEPTH(FRAME_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bfr_emitter #(.FRAME_DEPTH(FRAME_DEPTH)) u_emitter (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .em_stat (em_stat),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .out_bus (out_bus)
  );

endmodule

### design/bfr_ram.sv
module bfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/bfr_parser.sv
module bfr_parser import bfr_pkg::*; #(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bfr_in_if.sink                         in_bus,
  bfr_cfg_if.sink                        cfg_bus,
  input  bfr_em_stat_t                   em_stat,
  output bfr_ctl_t                       ctl,
  output logic                           wr_en,
  output logic [$clog2(FRAME_DEPTH)-1:0] wr_addr,
  output logic [DATA_W-1:0]              wr_data
);

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(FRAME_DEPTH);

  logic [DATA_W-1:0] start_r, stop_r, esc_byte_r;
  logic [LEN_W-1:0]  fill_r, fill_nxt, fill_inc;
  logic              in_frame_r, in_frame_nxt;
  logic              esc_r, esc_nxt;
  logic              rpt_valid_r, rpt_valid_nxt;
  status_t           rpt_code_r, rpt_code_nxt;
  logic              accept;
  logic [DATA_W-1:0] b;
  logic              emit_start;
  logic              set_rpt;
  status_t           set_code;

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = !em_stat.busy && !rpt_valid_r;
  assign accept        = in_bus.valid && in_bus.ready;
  assign b             = in_bus.rx_byte;
  assign fill_inc      = fill_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= START_BYTE_RST;
      stop_r     <= STOP_BYTE_RST;
      esc_byte_r <= ESC_BYTE_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        CFG_START:  start_r    <= cfg_bus.data;
        CFG_STOP:   stop_r     <= cfg_bus.data;
        CFG_ESCAPE: esc_byte_r <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    fill_nxt     = fill_r;
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    wr_en        = 1'b0;
    wr_addr      = fill_r[AW-1:0];
    wr_data      = b;
    emit_start   = 1'b0;
    set_rpt      = 1'b0;
    set_code     = ST_DATA;
    if (accept) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
        if ((b & ESC_FLIP) != '0) begin
          fill_nxt     = '0;
          in_frame_nxt = 1'b0;
          set_rpt      = 1'b1;
          set_code     = ST_ESC_ERR;
        end else if (in_frame_r) begin
          wr_en    = 1'b1;
          wr_data  = b ^ ESC_FLIP;
          fill_nxt = fill_inc;
          if (fill_inc >= DEPTH_LEN) begin
            fill_nxt     = '0;
            in_frame_nxt = 1'b0;
            set_rpt      = 1'b1;
            set_code     = ST_OVERSIZE;
          end
        end
      end else if (b == esc_byte_r) begin
        esc_nxt = 1'b1;
      end else if (in_frame_r && b == stop_r) begin
        // closing byte goes in unchecked, then the whole frame is read out
        wr_en        = 1'b1;
        emit_start   = 1'b1;
        fill_nxt     = '0;
        in_frame_nxt = 1'b0;
      end else if (b == start_r) begin
        wr_en        = 1'b1;
        wr_addr      = '0;
        fill_nxt     = LEN_W'(1);
        in_frame_nxt = 1'b1;
        if (in_frame_r) begin
          set_rpt  = 1'b1;
          set_code = ST_START_IN;
        end
      end else if (b == stop_r) begin
        set_rpt  = 1'b1;
        set_code = ST_STOP_IDLE;
      end else if (in_frame_r) begin
        wr_en    = 1'b1;
        fill_nxt = fill_inc;
        if (fill_inc >= DEPTH_LEN) begin
          fill_nxt     = '0;
          in_frame_nxt = 1'b0;
          set_rpt      = 1'b1;
          set_code     = ST_OVERSIZE;
        end
      end
    end
  end

  always_comb begin
    rpt_valid_nxt = rpt_valid_r;
    rpt_code_nxt  = rpt_code_r;
    if (set_rpt) begin
      rpt_valid_nxt = 1'b1;
      rpt_code_nxt  = set_code;
    end else if (em_stat.rpt_take) begin
      rpt_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      in_frame_r  <= 1'b0;
      esc_r       <= 1'b0;
      rpt_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      in_frame_r  <= in_frame_nxt;
      esc_r       <= esc_nxt;
      rpt_valid_r <= rpt_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rpt_code_r <= rpt_code_nxt;
  end

  assign ctl.rpt_valid  = rpt_valid_r;
  assign ctl.rpt_code   = rpt_code_r;
  assign ctl.emit_start = emit_start;
  assign ctl.emit_len   = fill_inc;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> (fill_r != '0 && fill_r < DEPTH_LEN))
    else $error("fill count out of range in an open frame");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> fill_r == '0)
    else $error("fill count nonzero while idle");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(set_rpt && emit_start))
    else $error("byte raised both a report and a frame");

endmodule

### design/bfr_emitter.sv
module bfr_emitter import bfr_pkg::*; #(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bfr_ctl_t                       ctl,
  output bfr_em_stat_t                   em_stat,
  output logic                           rd_en,
  output logic [$clog2(FRAME_DEPTH)-1:0] rd_addr,
  input  logic [DATA_W-1:0]              rd_data,
  bfr_out_if.source                      out_bus
);

  localparam int AW = $clog2(FRAME_DEPTH);

  em_state_t         state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_byte_r, out_byte_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_free, load_frame, load_rpt, issue;

  assign out_free   = !out_valid_r || out_bus.ready;
  assign load_frame = (state_r == EM_RUN) && pend_r && out_free;
  assign load_rpt   = (state_r == EM_IDLE) && ctl.rpt_valid && out_free;
  assign issue      = (state_r == EM_RUN) && (rd_idx_r < len_r) && (!pend_r || load_frame);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      EM_IDLE: if (ctl.emit_start) state_nxt = EM_RUN;
      EM_RUN:  if (rd_idx_r == len_r && (!pend_r || load_frame)) state_nxt = EM_IDLE;
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_comb begin
    len_nxt       = len_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    rd_en         = issue;
    rd_addr       = rd_idx_r[AW-1:0];
    case (state_r)
      EM_IDLE: begin
        if (ctl.emit_start) begin
          len_nxt    = ctl.emit_len;
          rd_idx_nxt = '0;
          pend_nxt   = 1'b0;
        end
      end
      EM_RUN: begin
        if (issue) begin
          rd_idx_nxt    = rd_idx_r + 1'b1;
          pend_nxt      = 1'b1;
          pend_last_nxt = (LEN_W'(rd_idx_r + 1'b1) == len_r);
        end else if (load_frame) begin
          pend_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    if (load_frame) begin
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = rd_data;
      out_status_nxt = ST_DATA;
      out_last_nxt   = pend_last_r;
    end else if (load_rpt) begin
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = '0;
      out_status_nxt = ctl.rpt_code;
      out_last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= EM_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r        <= len_nxt;
    rd_idx_r     <= rd_idx_nxt;
    pend_last_r  <= pend_last_nxt;
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign em_stat.busy     = (state_r != EM_IDLE);
  assign em_stat.rpt_take = load_rpt;

  assign out_bus.valid      = out_valid_r;
  assign out_bus.frame_byte = out_byte_r;
  assign out_bus.status     = out_status_r;
  assign out_bus.last       = out_last_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == EM_RUN |-> rd_idx_r <= len_r)
    else $error("read index passed frame length");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit_start |-> state_r == EM_IDLE)
    else $error("frame start while a frame is still being read out");

  a_no_rpt_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == EM_RUN |-> !ctl.rpt_valid)
    else $error("report pending during frame read-out");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    load_frame && pend_last_r |=> state_r == EM_IDLE)
    else $error("read-out did not finish after the last byte");

endmodule

### dv/byte_stuffed_frame_receiver_top_test.sv
module byte_stuffed_frame_receiver_top_test;
  import bfr_pkg::*;

  localparam int DEPTH         = FRAME_DEPTH_DEF;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  // index 3 decodes to no register
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] fbyte;
    status_t           st;
    logic              last;
  } frame_beat_t;

  logic clk;
  logic rst_n;

  bfr_in_if  in_bus ();
  bfr_out_if out_bus ();
  bfr_cfg_if cfg_bus ();

  byte_stuffed_frame_receiver_top #(.FRAME_DEPTH(DEPTH)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // deframer shadow state
  logic [DATA_W-1:0] mark_start;
  logic [DATA_W-1:0] mark_stop;
  logic [DATA_W-1:0] mark_esc;
  logic [DATA_W-1:0] held [0:DEPTH-1];
  logic [LEN_W-1:0]  held_cnt;
  logic              framing;
  logic              esc_armed;

  frame_beat_t expected_beats [$];

  int   in_gap_pct;
  int   out_stall_pct;
  logic out_hold;
  event hold_go;

  int cycle_count;
  int mismatches;
  int rx_count;
  int beats_seen;
  int frames_predicted;
  int faults_predicted;
  int cfg_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
               expected_beats.size());
      $display("byte_stuffed_frame_receiver_top_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- prediction

  function automatic void push_fault(input status_t code);
    expected_beats.push_back(frame_beat_t'{fbyte: '0, st: code, last: 1'b1});
    faults_predicted++;
  endfunction

  function automatic void hold_byte(input logic [DATA_W-1:0] b);
    held[held_cnt[5:0]] = b;
    held_cnt = held_cnt + 1'b1;
  endfunction

  // data byte of an open frame; a full store drops the frame
  function automatic void keep_byte(input logic [DATA_W-1:0] b);
    hold_byte(b);
    if (held_cnt >= DEPTH) begin
      held_cnt = '0;
      framing = 1'b0;
      push_fault(ST_OVERSIZE);
    end
  endfunction

  function automatic void predict_rx(input logic [DATA_W-1:0] b);
    logic was_open;
    int   n;
    if (esc_armed) begin
      esc_armed = 1'b0;
      if ((b & ESC_FLIP) != '0) begin
        held_cnt = '0;
        framing = 1'b0;
        push_fault(ST_ESC_ERR);
      end else if (framing) begin
        keep_byte(b ^ ESC_FLIP);
      end
      return;
    end
    if (b == mark_esc) begin
      esc_armed = 1'b1;
      return;
    end
    if (framing && b == mark_stop) begin
      hold_byte(b);
      n = (held_cnt > DEPTH) ? DEPTH : int'(held_cnt);
      for (int k = 0; k < n; k++)
        expected_beats.push_back(frame_beat_t'{fbyte: held[k], st: ST_DATA,
                                               last: (k == n - 1)});
      frames_predicted++;
      held_cnt = '0;
      framing = 1'b0;
      return;
    end
    if (b == mark_start) begin
      was_open = framing;
      held_cnt = '0;
      framing = 1'b1;
      hold_byte(b);
      if (was_open) push_fault(ST_START_IN);
      return;
    end
    if (b == mark_stop) begin
      push_fault(ST_STOP_IDLE);
      return;
    end
    if (framing) keep_byte(b);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 20) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk) begin : check_beat
    frame_beat_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte=%h status=%0d last=%b",
                                  out_bus.frame_byte, out_bus.status, out_bus.last));
      end else begin
        want = expected_beats.pop_front();
        if (out_bus.frame_byte !== want.fbyte || out_bus.status !== want.st ||
            out_bus.last !== want.last)
          report_mismatch($sformatf(
            "got byte=%h status=%0d last=%b, want byte=%h status=%0d last=%b",
            out_bus.frame_byte, out_bus.status, out_bus.last,
            want.fbyte, want.st, want.last));
      end
    end
  end

  // ---------------------------------------------------------------- result side

  initial begin
    out_hold <= 1'b0;
    forever begin
      @(hold_go);
      out_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_hold <= 1'b0;
    end
  end

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= !out_hold && ($urandom_range(99) >= out_stall_pct);
    end
  end

  // ---------------------------------------------------------------- line side

  // valid stays high after the beat; wait_drain or a gap lowers it
  task automatic send_rx(input logic [DATA_W-1:0] b);
    if ($urandom_range(99) < in_gap_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_rx(b);
    rx_count++;
  endtask

  task automatic wait_drain();
    in_bus.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    // bytes that make no beat may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      CFG_START:  mark_start = d;
      CFG_STOP:   mark_stop  = d;
      CFG_ESCAPE: mark_esc   = d;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_marks(input logic [DATA_W-1:0] s, input logic [DATA_W-1:0] p,
                           input logic [DATA_W-1:0] e);
    cfg_put(CFG_START, s);
    cfg_put(CFG_STOP, p);
    cfg_put(CFG_ESCAPE, e);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic is_mark(input logic [DATA_W-1:0] v);
    return v == mark_start || v == mark_stop || v == mark_esc;
  endfunction

  // a mark byte can only travel escaped, which needs bit 5 set
  function automatic logic [DATA_W-1:0] pick_payload();
    logic [DATA_W-1:0] v;
    v = DATA_W'($urandom);
    while (is_mark(v) && !v[5]) v = DATA_W'($urandom);
    return v;
  endfunction

  task automatic send_frame(input int len);
    logic [DATA_W-1:0] v;
    send_rx(mark_start);
    for (int i = 0; i < len; i++) begin
      v = pick_payload();
      if (is_mark(v) || (v[5] && $urandom_range(4) == 0)) begin
        send_rx(mark_esc);
        send_rx(v ^ ESC_FLIP);
      end else begin
        send_rx(v);
      end
    end
    send_rx(mark_stop);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_default_marks();
    send_rx(8'h00);                  // noise while idle
    send_rx(8'h7E);
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(8'h7D); send_rx(8'h5E);  // escaped flag
    send_rx(8'h7D); send_rx(8'h5D);  // escaped escape
    send_rx(8'h7E);                  // closes, whole frame comes out
    send_rx(8'h7D); send_rx(8'h01);  // escaped data while idle is dropped
    send_rx(8'h7D); send_rx(8'h7D);  // escape after escape: bit 5 set, fault
    send_rx(8'h7E); send_rx(8'h11);
    send_rx(8'h7D); send_rx(8'h20);  // fault inside a frame
    send_rx(8'h7E); send_rx(8'h7E);  // shortest frame
    wait_drain();
  endtask

  task automatic test_distinct_marks();
    cfg_put(CFG_START, 8'h02);
    cfg_put(CFG_STOP, 8'h03);
    cfg_put(CFG_ESCAPE, 8'h10);
    cfg_put(CFG_UNUSED, 8'h55);
    cfg_bus.valid <= 1'b0;
    send_rx(8'h03);                  // stop while idle
    send_rx(8'h02); send_rx(8'h41);
    send_rx(8'h02);                  // restart inside a frame
    send_rx(8'h42);
    send_rx(8'h10); send_rx(8'h13);
    send_rx(8'h03);
    wait_drain();
  endtask

  task automatic test_extreme_marks();
    set_marks(8'h00, 8'hFF, 8'h80);
    send_rx(8'h00); send_rx(8'h01); send_rx(8'hFF);
    send_rx(8'hFF);
    send_rx(8'h80); send_rx(8'hA1);
    send_rx(8'h80); send_rx(8'h5F);
    wait_drain();
  endtask

  task automatic test_random_mix(input int gap_pct, input int stall_pct, input int n_items,
                                 input logic rand_marks, input logic [DATA_W-1:0] s,
                                 input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] e);
    int goal;
    int kind;
    logic [DATA_W-1:0] rs, rp, re;
    in_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    rs = s; rp = p; re = e;
    if (rand_marks) begin
      rs = DATA_W'($urandom);
      rp = ($urandom_range(3) == 0) ? rs : DATA_W'($urandom);
      while (rp == rs && $urandom_range(1) == 0) rp = DATA_W'($urandom);
      re = DATA_W'($urandom);
      while (re == rs || re == rp) re = DATA_W'($urandom);
    end
    set_marks(rs, rp, re);
    goal = rx_count + n_items;
    while (rx_count < goal) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        send_frame($urandom_range(0, 6));
      end else if (kind == 7) begin
        send_rx(($urandom_range(1) == 0) ? mark_stop : DATA_W'($urandom));
      end else if (kind == 8) begin
        send_rx(mark_esc);
        send_rx(DATA_W'($urandom) | ESC_FLIP);
      end else begin
        // frame cut short, the next start restarts it
        send_rx(mark_start);
        repeat ($urandom_range(0, 3)) send_rx(DATA_W'($urandom));
      end
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    in_gap_pct = 0;
    out_stall_pct = 0;
    set_marks(START_BYTE_RST, STOP_BYTE_RST, ESC_BYTE_RST);
    -> hold_go;
    send_frame(DEPTH - 2);           // largest frame that still closes
    send_rx(mark_esc); send_rx(8'hFF);
    send_frame(DEPTH - 1);           // overfills
    send_frame(0);
    wait_drain();
  endtask

  initial begin
    in_bus.valid   <= 1'b0;
    in_bus.rx_byte <= '0;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= CFG_START;
    cfg_bus.data   <= '0;
    rst_n          <= 1'b0;
    mark_start = START_BYTE_RST;
    mark_stop  = STOP_BYTE_RST;
    mark_esc   = ESC_BYTE_RST;
    held_cnt   = '0;
    framing    = 1'b0;
    esc_armed  = 1'b0;
    in_gap_pct = 7;
    out_stall_pct = 46;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_default_marks();
    test_distinct_marks();
    test_extreme_marks();
    test_random_mix(7, 46, 10, 1'b1, '0, '0, '0);
    test_random_mix(46, 7, 10, 1'b0, 8'hFF, 8'h00, 8'h20);
    test_random_mix(0, 0, 10, 1'b0, START_BYTE_RST, STOP_BYTE_RST, ESC_BYTE_RST);
    test_backpressure();

    $display("line bytes %0d, config writes %0d, output beats %0d", rx_count, cfg_writes,
             beats_seen);
    $display("frames %0d, fault reports %0d, mismatches %0d", frames_predicted,
             faults_predicted, mismatches);
    if (mismatches == 0) begin
      $display("byte_stuffed_frame_receiver_top_test passed");
    end else begin
      $display("byte_stuffed_frame_receiver_top_test failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/bfr_pkg.sv
design/bfr_in_if.sv
design/bfr_out_if.sv
design/bfr_cfg_if.sv
design/bfr_ram.sv
design/bfr_parser.sv
design/bfr_emitter.sv
design/byte_stuffed_frame_receiver_top.sv
dv/byte_stuffed_frame_receiver_top_test.sv
